// File: src/ipv4dq_pkg.sv
// ipv4dq_pkg: request and result types, scan state and reason codes
// for the dotted-quad checker; no dependencies

package ipv4dq_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2e;

    localparam logic [2:0] MIN_LENGTH = 3'd7;
    localparam logic [1:0] DOTS_FULL  = 2'd3;
    localparam logic [8:0] FIELD_MAX  = 9'd255;
    localparam logic [8:0] FIELD_SAT  = 9'd256;

    localparam logic [2:0] RSN_OK        = 3'd0;
    localparam logic [2:0] RSN_SHORT     = 3'd1;
    localparam logic [2:0] RSN_BAD_CHAR  = 3'd2;
    localparam logic [2:0] RSN_EXTRA_DOT = 3'd3;
    localparam logic [2:0] RSN_EMPTY     = 3'd4;
    localparam logic [2:0] RSN_OVER      = 3'd5;
    localparam logic [2:0] RSN_DOT_COUNT = 3'd6;
    localparam logic [2:0] RSN_TRAIL_DOT = 3'd7;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } req_t;

    typedef struct packed {
        logic       valid_res;
        logic [2:0] reason;
    } rsp_t;

    typedef struct packed {
        logic [2:0] length_seen;
        logic [1:0] dots_seen;
        logic [8:0] field_value;
        logic       field_nonempty;
        logic       prev_was_dot;
        logic [2:0] first_error;
    } scan_state_t;

endpackage

// File: src/ipv4_dotted_quad_check_core.sv
// ipv4_dotted_quad_check_core: dotted-quad address checker, one character per request
// depends on ipv4dq_pkg and ipv4dq_scan
//
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  req_data (character, last_char)
// result    out        rsp_valid / rsp_stall  rsp_data (valid_res, reason)
//
// one request per cycle sustained unless a stalled result blocks a last character; a result is registered
// the request register feeds the scan logic, which writes the state and result registers
// asynchronous active-low reset empties both registers and clears the scan state
// a stalled result holds only a last character in the request register; others still pass

module ipv4_dotted_quad_check_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ipv4dq_pkg::req_t   req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ipv4dq_pkg::rsp_t   rsp_data
);

    logic                    hold_valid_reg;
    logic                    hold_valid_next;
    ipv4dq_pkg::req_t        hold_reg;
    ipv4dq_pkg::scan_state_t state_reg;
    ipv4dq_pkg::scan_state_t state_next;
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    ipv4dq_pkg::rsp_t        rsp_reg;
    ipv4dq_pkg::rsp_t        scan_rsp;
    logic                    out_free;
    logic                    consume;
    logic                    take;

    ipv4dq_scan u_scan (
        .state      (state_reg),
        .req        (hold_reg),
        .state_next (state_next),
        .rsp        (scan_rsp)
    );

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign consume   = hold_valid_reg && (!hold_reg.last_char || out_free);
    assign req_stall = hold_valid_reg && !consume;
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
            hold_valid_next = 1'b1;
        else if (consume)
            hold_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (consume && hold_reg.last_char)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (consume)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            hold_reg <= req_data;
        if (consume && hold_reg.last_char)
            rsp_reg <= scan_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // verdict agrees with reason code
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.valid_res == (rsp_data.reason == ipv4dq_pkg::RSN_OK)))
        else $error("valid_res disagrees with reason");

    // scan state clears after the last character
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && hold_reg.last_char) |=> (state_reg == '0))
        else $error("scan state not cleared after last character");

    // an error is only recorded once a character has been counted
    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.first_error != ipv4dq_pkg::RSN_OK) |-> (state_reg.length_seen != 3'd0))
        else $error("error recorded with zero length");

    // stall only while the request register is occupied by a blocked last character
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (hold_valid_reg && hold_reg.last_char && rsp_valid && rsp_stall))
        else $error("request stalled without cause");

endmodule

// File: src/ipv4dq_scan.sv
// ipv4dq_scan: per-character next-state and verdict logic
// depends on ipv4dq_pkg

module ipv4dq_scan (
    input  ipv4dq_pkg::scan_state_t state,
    input  ipv4dq_pkg::req_t        req,
    output ipv4dq_pkg::scan_state_t state_next,
    output ipv4dq_pkg::rsp_t        rsp
);

    logic                    is_digit;
    logic                    is_dot;
    logic                    leading;
    logic [11:0]             acc;
    ipv4dq_pkg::scan_state_t upd;
    logic [2:0]              reason;

    always_comb
    begin
        is_digit = req.character inside {[ipv4dq_pkg::CHAR_ZERO : ipv4dq_pkg::CHAR_NINE]};
        is_dot   = (req.character == ipv4dq_pkg::CHAR_DOT);
        leading  = (state.length_seen == 3'd0);
        acc      = ({3'b000, state.field_value} * 12'd10)
                 + {4'b0000, req.character - ipv4dq_pkg::CHAR_ZERO};
        upd      = state;

        if (state.first_error == ipv4dq_pkg::RSN_OK)
        begin
            if (leading && !is_digit)
            begin
                upd.first_error = ipv4dq_pkg::RSN_BAD_CHAR;
            end
            else if (is_digit)
            begin
                upd.field_value    = (acc > {3'b000, ipv4dq_pkg::FIELD_MAX}) ?
                                     ipv4dq_pkg::FIELD_SAT : acc[8:0];
                upd.field_nonempty = 1'b1;
            end
            else if (is_dot)
            begin
                if (state.dots_seen == ipv4dq_pkg::DOTS_FULL)
                begin
                    upd.first_error = ipv4dq_pkg::RSN_EXTRA_DOT;
                end
                else
                begin
                    upd.dots_seen = state.dots_seen + 2'd1;
                    if (!state.field_nonempty)
                        upd.first_error = ipv4dq_pkg::RSN_EMPTY;
                    else if (state.field_value > ipv4dq_pkg::FIELD_MAX)
                        upd.first_error = ipv4dq_pkg::RSN_OVER;
                    upd.field_value    = '0;
                    upd.field_nonempty = 1'b0;
                end
            end
            else
            begin
                upd.first_error = ipv4dq_pkg::RSN_BAD_CHAR;
            end
        end

        upd.prev_was_dot = is_dot;
        if (state.length_seen != ipv4dq_pkg::MIN_LENGTH)
            upd.length_seen = state.length_seen + 3'd1;

        if (upd.length_seen != ipv4dq_pkg::MIN_LENGTH)
            reason = ipv4dq_pkg::RSN_SHORT;
        else if (upd.first_error != ipv4dq_pkg::RSN_OK)
            reason = upd.first_error;
        else if (upd.dots_seen != ipv4dq_pkg::DOTS_FULL)
            reason = ipv4dq_pkg::RSN_DOT_COUNT;
        else if (upd.prev_was_dot)
            reason = ipv4dq_pkg::RSN_TRAIL_DOT;
        else if (upd.field_value > ipv4dq_pkg::FIELD_MAX)
            reason = ipv4dq_pkg::RSN_OVER;
        else
            reason = ipv4dq_pkg::RSN_OK;

        rsp.reason    = reason;
        rsp.valid_res = (reason == ipv4dq_pkg::RSN_OK);
        state_next    = req.last_char ? '0 : upd;
    end

endmodule
